>>> rtl/core/cbp_pkg.sv
// Package for the prefix code bit packer: widths, request and op codes,
// and the buffer-load struct. No dependencies.
package cbp_pkg;

  localparam int CBP_MAX_CODE_LEN = 32;
  localparam int CBP_SYMBOL_COUNT = 256;

  localparam int REQ_W        = 2;
  localparam int SYM_W        = 8;
  localparam int LEN_W        = 6;
  localparam int CODE_FIELD_W = 32;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = 7;
  // byte count per transaction: at most 4 bytes for codes of up to 32 bits
  localparam int NBY_W        = 3;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ENC,
    OP_FLUSH
  } cbp_op_t;

  typedef struct packed {
    logic             vld;
    logic [NBY_W-1:0] nbytes;
  } cbp_load_t;

endpackage

>>> rtl/core/cbp_if.sv
// Valid/ready channel interfaces for request and byte transactions.
// Depends on cbp_pkg.
interface cbp_in_if import cbp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [SYM_W-1:0]        symbol;
  logic [LEN_W-1:0]        code_length;
  logic [CODE_FIELD_W-1:0] code_bits;

  modport source (output valid, req_type, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, req_type, symbol, code_length, code_bits, output ready);
endinterface

interface cbp_out_if import cbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

>>> rtl/core/prefix_code_bit_packer.sv
// Prefix code bit packer: a request is registered with its table read in the packing
// stage, then its bytes in the output buffer. One request per cycle while the buffer is
// free; a request's bytes (up to 4) leave one per cycle while the consumer is ready.
// Reset (sync, active low) clears pending bits, the packing stage and the byte buffer;
// the code table RAM is not cleared and an entry must be loaded before it is encoded.
module prefix_code_bit_packer import cbp_pkg::*; #(
  parameter int MAX_CODE_LEN = CBP_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = CBP_SYMBOL_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  cbp_in_if.sink    in_ch,
  cbp_out_if.source out_ch
);

  // Stored code width: the field is 32 bits, the parameter may cap it lower.
  localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  // Most bytes one code can complete, with up to 7 bits already pending.
  localparam int NB_MAX = (CODE_W + PEND_W) / BYTE_W;
  localparam int TLEN_W = $clog2(CODE_W + 1);
  localparam int RAM_W  = TLEN_W + CODE_W;
  localparam int ADDR_W = $clog2(SYMBOL_COUNT);

  logic                          accept;
  logic                          in_range;
  logic [TLEN_W-1:0]             len_sat;
  cbp_op_t                       op_in;
  logic [RAM_W-1:0]              rdata;
  logic                          buf_free;
  cbp_load_t                     ld;
  logic [NB_MAX-1:0][BYTE_W-1:0] bytes;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = ({1'b0, in_ch.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

  // Loaded lengths saturate to the stored code width.
  assign len_sat = (in_ch.code_length > LEN_W'(CODE_W)) ? TLEN_W'(CODE_W)
                                                        : TLEN_W'(in_ch.code_length);

  // Loads write the table at acceptance and leave nothing for the packing stage.
  // Out-of-range encodes, loads and unknown requests travel as no-ops so that
  // ordering through the stage stays simple.
  always_comb begin
    op_in = OP_NOP;
    unique case (in_ch.req_type)
      REQ_ENC:   op_in = in_range ? OP_ENC : OP_NOP;
      REQ_FLUSH: op_in = OP_FLUSH;
      default:   op_in = OP_NOP;
    endcase
  end

  // Code table. A load accepted in the cycle before an encode of the same
  // symbol is visible to it, since the write lands at the edge before the read.
  cbp_ram #(
    .W     (RAM_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (accept && (in_ch.req_type == REQ_LOAD) && in_range),
    .waddr (in_ch.symbol[ADDR_W-1:0]),
    .wdata ({len_sat, in_ch.code_bits[CODE_W-1:0]}),
    .re    (accept && (op_in == OP_ENC)),
    .raddr (in_ch.symbol[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Packing stage; read data stays put while the stage is stalled because
  // no new read is issued until it advances.
  cbp_pack #(
    .CODE_W (CODE_W),
    .NB_MAX (NB_MAX)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_i    (accept),
    .op_i      (op_in),
    .rd_len_i  (rdata[RAM_W-1:CODE_W]),
    .rd_code_i (rdata[CODE_W-1:0]),
    .free_i    (buf_free),
    .ready_o   (in_ch.ready),
    .ld_o      (ld),
    .bytes_o   (bytes)
  );

  // Result register: decouples the packing stage from a stalled consumer.
  cbp_outbuf #(
    .NB_MAX (NB_MAX)
  ) u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_i    (ld),
    .bytes_i (bytes),
    .free_o  (buf_free),
    .out_ch  (out_ch)
  );

  // Bytes of a transaction are never overwritten before they drain.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld.vld |-> buf_free)
    else $error("byte buffer loaded while bytes remain");

  // A buffer load carries between one and NB_MAX bytes.
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    ld.vld |-> (ld.nbytes != '0) && (ld.nbytes <= NBY_W'(NB_MAX)))
    else $error("bad byte count on buffer load");

  // A run of bytes from one request continues without a gap.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("gap inside a byte run");

  // Input backpressure only ever comes from bytes waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("request stalled with empty output");

endmodule

>>> rtl/core/cbp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cbp_ram #(
  parameter int W     = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/cbp_pack.sv
// Packing stage: holds one request, merges its code with the pending bits
// and hands finished bytes to the output buffer. Depends on cbp_pkg.
module cbp_pack import cbp_pkg::*; #(
  parameter int CODE_W = 32,
  parameter int NB_MAX = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take_i,
  input  cbp_op_t                          op_i,
  input  logic [$clog2(CODE_W+1)-1:0]      rd_len_i,
  input  logic [CODE_W-1:0]                rd_code_i,
  input  logic                             free_i,
  output logic                             ready_o,
  output cbp_load_t                        ld_o,
  output logic [NB_MAX-1:0][BYTE_W-1:0]    bytes_o
);

  localparam int TLEN_W = $clog2(CODE_W + 1);
  localparam int LA_W   = NB_MAX * BYTE_W + BYTE_W;
  localparam int CNT_W  = $clog2(CODE_W + PEND_W + 1);

  logic              s1_vld_r;
  cbp_op_t           op_r;
  logic [PEND_W-1:0] pend_r, pend_nxt;    // pending bits, left-aligned, zero below
  logic [2:0]        pcnt_r, pcnt_nxt;

  logic [TLEN_W-1:0] len_eff;
  logic [CODE_W-1:0] code_al;
  logic [LA_W-1:0]   la;
  logic [CNT_W-1:0]  cnt;
  logic [NBY_W-1:0]  nb_enc, nb;
  logic [BYTE_W-1:0] res;
  logic              adv;

  always_comb begin
    len_eff = (rd_len_i > TLEN_W'(CODE_W)) ? TLEN_W'(CODE_W) : rd_len_i;
    code_al = rd_code_i << (TLEN_W'(CODE_W) - len_eff);
    la      = {pend_r, {(LA_W-PEND_W){1'b0}}}
            | ({code_al, {(LA_W-CODE_W){1'b0}}} >> pcnt_r);
    cnt     = CNT_W'(pcnt_r) + CNT_W'(len_eff);
    nb_enc  = NBY_W'(cnt >> 3);

    res = '0;
    for (int k = 0; k <= NB_MAX; k++) begin
      if (nb_enc == NBY_W'(k)) begin
        res = la[LA_W-1-BYTE_W*k -: BYTE_W];
      end
    end

    for (int k = 0; k < NB_MAX; k++) begin
      bytes_o[k] = la[LA_W-1-BYTE_W*k -: BYTE_W];
    end

    nb       = '0;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    unique case (op_r)
      OP_ENC: begin
        nb       = nb_enc;
        pend_nxt = res[BYTE_W-1:1];
        pcnt_nxt = cnt[2:0];
      end
      OP_FLUSH: begin
        nb         = (pcnt_r != 3'd0) ? NBY_W'(1) : '0;
        bytes_o[0] = {pend_r, 1'b0};
        pend_nxt   = '0;
        pcnt_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign adv        = s1_vld_r && ((nb == '0) || free_i);
  assign ready_o    = !s1_vld_r || adv;
  assign ld_o.vld    = adv && (nb != '0);
  assign ld_o.nbytes = nb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      op_r     <= OP_NOP;
      pend_r   <= '0;
      pcnt_r   <= '0;
    end else begin
      if (ready_o) begin
        s1_vld_r <= take_i;
        op_r     <= op_i;
      end
      if (adv) begin
        pend_r <= pend_nxt;
        pcnt_r <= pcnt_nxt;
      end
    end
  end

endmodule

>>> rtl/core/cbp_outbuf.sv
// Output byte buffer: holds one transaction's bytes and drains them onto
// the result channel, one per cycle if ready. Depends on cbp_pkg, cbp_if.
module cbp_outbuf import cbp_pkg::*; #(
  parameter int NB_MAX = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbp_load_t                     ld_i,
  input  logic [NB_MAX-1:0][BYTE_W-1:0] bytes_i,
  output logic                          free_o,
  cbp_out_if.source                     out_ch
);

  localparam int NB_W = $clog2(NB_MAX + 1);

  logic [NB_MAX-1:0][BYTE_W-1:0] buf_r, buf_nxt;
  logic [NB_W-1:0]               rem_r, rem_nxt;
  logic                          pop;

  assign out_ch.valid       = (rem_r != '0);
  assign out_ch.out_byte    = buf_r[0];
  assign out_ch.last_of_run = (rem_r == NB_W'(1));
  assign pop                = out_ch.valid && out_ch.ready;
  assign free_o             = (rem_r == '0) || ((rem_r == NB_W'(1)) && pop);

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (ld_i.vld) begin
      buf_nxt = bytes_i;
      rem_nxt = NB_W'(ld_i.nbytes);
    end else if (pop) begin
      for (int k = 0; k < NB_MAX - 1; k++) begin
        buf_nxt[k] = buf_r[k+1];
      end
      rem_nxt = rem_r - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> tb/cbp_byte_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the prefix code bit packer: mirrors the code table and the bit
// accumulator, predicts each packed byte and compares it with the result channel.
// Depends on cbp_pkg and the channel interfaces in cbp_if.
module cbp_byte_checker import cbp_pkg::*; #(
  parameter int MAX_CODE_LEN = CBP_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = CBP_SYMBOL_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  cbp_in_if    in_mon,
  cbp_out_if   out_mon,
  output int   fails,
  output int   outstanding,
  output int   bytes_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] octet;
    logic              last_flag;
  } packed_byte_t;

  logic [LEN_W-1:0]        len_tbl  [SYMBOL_COUNT];
  logic [CODE_FIELD_W-1:0] code_tbl [SYMBOL_COUNT];
  logic [PEND_W-1:0]       acc_bits;
  int                      acc_cnt;
  packed_byte_t            expected_bytes [$];
  int                      fail_cnt;
  int                      byte_cnt;

  // Applies one request to the mirrored state and queues the bytes it yields.
  task automatic pack_request(input logic [REQ_W-1:0]        kind,
                              input logic [SYM_W-1:0]        sym,
                              input logic [LEN_W-1:0]        len_in,
                              input logic [CODE_FIELD_W-1:0] bits_in);
    logic [63:0]       acc;
    logic [BYTE_W-1:0] tail;
    int                cnt;
    int                len;
    case (kind)
      REQ_LOAD: begin
        len = len_in;
        if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
        if (len > CODE_FIELD_W) len = CODE_FIELD_W;
        if (sym < SYMBOL_COUNT) begin
          len_tbl[sym]  = LEN_W'(len);
          code_tbl[sym] = bits_in;
        end
      end
      REQ_ENC: begin
        if (sym < SYMBOL_COUNT) begin
          len = len_tbl[sym];
          acc = (64'(acc_bits) << len) | (64'(code_tbl[sym]) & ((64'd1 << len) - 64'd1));
          cnt = acc_cnt + len;
          while (cnt >= BYTE_W) begin
            // the byte that leaves fewer than 8 bits behind is the last one
            expected_bytes.push_back('{octet: BYTE_W'(acc >> (cnt - BYTE_W)),
                                       last_flag: (cnt < 2 * BYTE_W)});
            cnt -= BYTE_W;
          end
          acc_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
          acc_cnt  = cnt;
        end
      end
      REQ_FLUSH: begin
        if (acc_cnt != 0) begin
          tail = BYTE_W'(acc_bits);
          tail = tail << (BYTE_W - acc_cnt);
          expected_bytes.push_back('{octet: tail, last_flag: 1'b1});
          acc_bits = '0;
          acc_cnt  = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      acc_bits = '0;
      acc_cnt  = 0;
      expected_bytes.delete();
    end else begin
      // results first: a byte seen at this edge never belongs to this edge's request
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: byte with nothing expected: expected none, actual %02h last %0b",
                   $time, out_mon.out_byte, out_mon.last_of_run);
          fail_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.out_byte !== want.octet) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.octet, out_mon.out_byte);
            fail_cnt++;
          end
          if (out_mon.last_of_run !== want.last_flag) begin
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last_flag, out_mon.last_of_run);
            fail_cnt++;
          end
          byte_cnt++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        pack_request(in_mon.req_type, in_mon.symbol, in_mon.code_length, in_mon.code_bits);
    end
    fails         <= fail_cnt;
    outstanding   <= expected_bytes.size();
    bytes_checked <= byte_cnt;
  end

endmodule

>>> tb/tb_prefix_code_bit_packer.sv
`timescale 1ns / 100ps
// Top of the prefix code bit packer testbench: clock, reset, request and
// result-side drivers, verdict. Depends on cbp_pkg, cbp_if and cbp_byte_checker.
module tb_prefix_code_bit_packer;
  import cbp_pkg::*;

  // req_type 3 has no meaning; the block must swallow it silently
  localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;

  localparam int RANDOM_REQS  = 210;     // random requests, ignored ones not counted
  localparam int LONG_HOLD    = 150;     // one long result-side stall, in cycles
  localparam int HOLD_AFTER   = 40;      // bytes taken before that stall starts
  localparam int DRAIN_CYCLES = 20;      // quiet time after the last expected byte
  localparam int CYCLE_LIMIT  = 100_000; // far above the slowest legal run

  logic clk = 1'b0;
  logic rst_n;

  cbp_in_if  in_ch ();
  cbp_out_if out_ch ();

  int fails;
  int outstanding;
  int bytes_checked;

  // stimulus bookkeeping
  int n_load, n_enc, n_flush, n_rsvd;
  int cycles;
  int send_burst;  // transactions left that the sender offers back to back
  int take_burst;  // bytes left that the receiver takes back to back

  // Table entries are never cleared, so only symbols loaded at least once
  // may be encoded; this list is what the random encodes draw from.
  bit loaded [CBP_SYMBOL_COUNT];
  int loaded_syms [$];

  always #2 clk = ~clk;

  prefix_code_bit_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cbp_byte_checker byte_sb (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fails         (fails),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, outstanding);
      $display("tb_prefix_code_bit_packer NOT OK");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after its transaction.
  // valid is dropped only when a gap is drawn, so back-to-back transactions
  // keep it high without a second assignment in the same step.
  task automatic send_req(input logic [REQ_W-1:0]        kind,
                          input int                      sym,
                          input int                      len,
                          input logic [CODE_FIELD_W-1:0] bits);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type    <= kind;
    in_ch.symbol      <= SYM_W'(sym);
    in_ch.code_length <= LEN_W'(len);
    in_ch.code_bits   <= bits;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    case (kind)
      REQ_LOAD: begin
        n_load++;
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      REQ_ENC:   n_enc++;
      REQ_FLUSH: n_flush++;
      default:   n_rsvd++;
    endcase
  endtask

  // Result side: a random stall before each byte, runs of no stall, and once
  // a long stall so the block backs up and pushes back on requests.
  initial begin
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        gap  = LONG_HOLD;
        held = 1'b1;
      end else if (take_burst > 0) begin
        gap = 0;
        take_burst--;
      end else begin
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) take_burst = $urandom_range(5, 20);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
      @(negedge clk);
    end
  end

  // Request side: reset, directed cases, random traffic, drain, verdict.
  initial begin
    int pick;
    int sym;
    int len;
    int done;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_FLUSH;
    in_ch.symbol      <= '0;
    in_ch.code_length <= '0;
    in_ch.code_bits   <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    send_req(REQ_FLUSH, 0, $urandom_range(0, 63), $urandom());  // nothing pending yet
    send_req(REQ_LOAD, 0, 0, 32'hFFFF_FFFF);     // zero-length code, bits unused
    send_req(REQ_LOAD, 255, 32, 32'hFFFF_FFFF);  // longest legal code, all ones
    send_req(REQ_LOAD, 1, 1, 32'h0000_0001);
    send_req(REQ_LOAD, 2, 63, 32'hA5A5_A5A5);    // overlong length, top of the field
    send_req(REQ_LOAD, 3, 33, 32'h1234_5678);    // overlong by one
    send_req(REQ_LOAD, 4, 7, 32'h0000_0055);
    send_req(REQ_LOAD, 128, 8, 32'h0000_0000);   // exactly one byte of zeros
    send_req(REQ_ENC, 0, $urandom_range(0, 63), $urandom());  // appends nothing
    // seven single bits leave the accumulator full, then a 32-bit code on top
    // of it spills four bytes from one request
    repeat (7) send_req(REQ_ENC, 1, $urandom_range(0, 63), $urandom());
    send_req(REQ_ENC, 255, $urandom_range(0, 63), $urandom());
    send_req(REQ_FLUSH, 0, 0, 32'h0);            // pads the seven leftover bits
    send_req(REQ_ENC, 2, 0, 32'h0);
    send_req(REQ_ENC, 3, 0, 32'h0);
    send_req(REQ_ENC, 4, 0, 32'h0);
    send_req(REQ_ENC, 128, 0, 32'h0);
    send_req(REQ_RSVD, 255, 63, 32'hFFFF_FFFF);  // unknown request, all bits set
    send_req(REQ_FLUSH, 255, 63, 32'hFFFF_FFFF);
    send_req(REQ_FLUSH, 0, 0, 32'h0);            // second flush finds nothing

    // --- random ---
    // Mostly encodes of loaded symbols with loads mixed in so the table keeps
    // changing; lengths lean short but reach zero and the overlong range.
    done = 0;
    while (done < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        sym = $urandom_range(0, CBP_SYMBOL_COUNT - 1);
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(CODE_FIELD_W + 1, 63);
          2, 3, 4: len = $urandom_range(1, 8);
          default: len = $urandom_range(1, CODE_FIELD_W);
        endcase
        send_req(REQ_LOAD, sym, len, $urandom());
        done++;
      end else if (pick < 86) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_req(REQ_ENC, sym, $urandom_range(0, 63), $urandom());
        done++;
      end else if (pick < 96) begin
        send_req(REQ_FLUSH, $urandom_range(0, 255), $urandom_range(0, 63), $urandom());
        done++;
      end else begin
        send_req(REQ_RSVD, $urandom_range(0, 255), $urandom_range(0, 63), $urandom());
      end
    end
    in_ch.valid <= 1'b0;

    // wait out every expected byte, then watch for strays
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d table loads, %0d encodes, %0d flushes, %0d unknown requests",
             n_load, n_enc, n_flush, n_rsvd);
    $display("%0d packed bytes compared, one result-side stall of %0d cycles, %0d mismatches",
             bytes_checked, LONG_HOLD, fails);
    if (fails == 0) begin
      $display("tb_prefix_code_bit_packer OK");
    end else begin
      $display("tb_prefix_code_bit_packer NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cbp_pkg.sv
rtl/core/cbp_if.sv
rtl/core/cbp_ram.sv
rtl/core/cbp_pack.sv
rtl/core/cbp_outbuf.sv
rtl/core/prefix_code_bit_packer.sv
tb/cbp_byte_checker.sv
tb/tb_prefix_code_bit_packer.sv
